FILE: rtl/core/bfa_pkg.sv
`default_nettype none

package bfa_pkg;

  // Table geometry and field widths.
  localparam int ENTRIES = 32;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int UNIT_W  = 24;
  localparam int LEN_W   = UNIT_W + 1;
  localparam int POOL_W  = 25;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INIT  = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic simple;
    logic fit_clr;
    logic fit_step;
    logic fit_apply;
    logic fail;
    logic mrg_clr;
    logic mrg_step;
    logic mrg_link;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic alloc_req;
    logic best_found;
    logic cand_found;
    logic merged;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/best_fit_allocator_coalescing_unit.sv
// Best-fit allocator over a 32-entry free table with coalescing on demand. A
// request is taken when start is high and busy is low; its single result
// appears on the out_ ports for one cycle with out_valid, and the receiver
// cannot stall it. Init, free and zero-unit requests go from dispatch straight
// back to idle. An allocation scans the table one entry per cycle through a
// single read port. When nothing fits, each merge pass walks the valid entries
// in offset order, one full table scan per entry, and is followed by a rescan
// if it joined any blocks. pool_units is written through cfg_we and cfg_wdata
// while the unit is idle, a rule for the user that the unit itself does not
// enforce; it takes effect at the next init.
`default_nettype none

module best_fit_allocator_coalescing_unit import bfa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [POOL_W-1:0] cfg_wdata,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [UNIT_W-1:0] in_block_offset,
  input  wire logic [LEN_W-1:0]  in_block_units,
  output logic                   out_valid,
  output logic [UNIT_W-1:0]      out_granted_offset,
  output logic [STAT_W-1:0]      out_status
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  bfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Free table and scan datapath.
  bfa_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_kind            (in_kind),
    .in_block_offset    (in_block_offset),
    .in_block_units     (in_block_units),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_granted_offset (out_granted_offset),
    .out_status         (out_status)
  );

endmodule

`default_nettype wire

FILE: rtl/core/bfa_ctrl.sv
`default_nettype none

module bfa_ctrl import bfa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_FIT      = 3'd2;
  localparam logic [2:0] S_FIT_END  = 3'd3;
  localparam logic [2:0] S_MRG      = 3'd4;
  localparam logic [2:0] S_MRG_END  = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.alloc_req) begin
          cmd.fit_clr = 1'b1;
          state_nxt   = S_FIT;
        end else begin
          cmd.simple = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_FIT: begin
        cmd.fit_step = 1'b1;
        if (sts.last) begin
          state_nxt = S_FIT_END;
        end
      end
      S_FIT_END: begin
        if (sts.best_found) begin
          cmd.fit_apply = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.mrg_clr = 1'b1;
          state_nxt   = S_MRG;
        end
      end
      S_MRG: begin
        cmd.mrg_step = 1'b1;
        if (sts.last) begin
          state_nxt = S_MRG_END;
        end
      end
      S_MRG_END: begin
        if (sts.cand_found) begin
          cmd.mrg_link = 1'b1;
          state_nxt    = S_MRG;
        end else if (sts.merged) begin
          cmd.fit_clr = 1'b1;
          state_nxt   = S_FIT;
        end else begin
          cmd.fail  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.simple, cmd.fit_apply, cmd.fail}))
    else $error("More than one result command in a cycle.");
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.simple || cmd.fit_apply || cmd.fail) |=> (state_r == S_IDLE))
    else $error("Controller did not return to idle after a result.");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_DISPATCH))
    else $error("Accepted request did not reach dispatch.");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/bfa_dpath.sv
`default_nettype none

module bfa_dpath import bfa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [POOL_W-1:0] cfg_wdata,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [UNIT_W-1:0] in_block_offset,
  input  wire logic [LEN_W-1:0]  in_block_units,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  output logic                   out_valid,
  output logic [UNIT_W-1:0]      out_granted_offset,
  output logic [STAT_W-1:0]      out_status
);

  localparam logic [POOL_W-1:0] POOL_MAX = POOL_W'(1) << UNIT_W;

  // Free table.
  logic [UNIT_W-1:0]  start_mem [ENTRIES];
  logic [LEN_W-1:0]   len_mem   [ENTRIES];
  logic [ENTRIES-1:0] valid_r, valid_nxt;

  logic [POOL_W-1:0]  pool_r;
  logic [KIND_W-1:0]  kind_r;
  logic [UNIT_W-1:0]  offs_r;
  logic [LEN_W-1:0]   units_r;
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  logic               best_found_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [UNIT_W-1:0]  best_start_r;
  logic [LEN_W-1:0]   best_len_r;

  logic               merged_r;
  logic               have_prev_r;
  logic [IDX_W-1:0]   prev_idx_r;
  logic [UNIT_W-1:0]  prev_start_r;
  logic [LEN_W-1:0]   prev_len_r;
  logic [UNIT_W-1:0]  key_start_r;
  logic [IDX_W-1:0]   key_idx_r;
  logic               cand_found_r;
  logic [IDX_W-1:0]   cand_idx_r;
  logic [UNIT_W-1:0]  cand_start_r;
  logic [LEN_W-1:0]   cand_len_r;

  logic               out_valid_r;
  logic [UNIT_W-1:0]  out_granted_r;
  logic [STAT_W-1:0]  out_status_r;

  logic [UNIT_W-1:0]  rd_start_r;
  logic [LEN_W-1:0]   rd_len_r;
  logic               fit_hit, mrg_hit, after_key;
  logic [POOL_W-1:0]  pool_cl;
  logic               free_avail;
  logic [IDX_W-1:0]   free_idx;
  logic               do_merge;
  logic [LEN_W:0]     len_sum;
  logic [LEN_W-1:0]   len_sat;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [UNIT_W-1:0]  wstart;
  logic [LEN_W-1:0]   wlen;

  // Status to the controller.
  assign sts.last       = (idx_r == IDX_W'(ENTRIES - 1));
  assign sts.alloc_req  = (kind_r == KIND_ALLOC) && (units_r != '0);
  assign sts.best_found = best_found_r;
  assign sts.cand_found = cand_found_r;
  assign sts.merged     = merged_r;

  // Scan index: cleared at the start of a scan, advanced once per step.
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.fit_clr || cmd.mrg_clr || cmd.mrg_link) begin
      idx_nxt = '0;
    end else if (cmd.fit_step || cmd.mrg_step) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  // Best-fit compare of the scanned entry against the best so far.
  assign fit_hit = valid_r[idx_r] && (rd_len_r >= units_r) &&
                   (!best_found_r || (rd_len_r < best_len_r) ||
                    ((rd_len_r == best_len_r) && (rd_start_r < best_start_r)));

  // Successor search: least (start, index) above the key of the last entry.
  assign after_key = !have_prev_r || (rd_start_r > key_start_r) ||
                     ((rd_start_r == key_start_r) && (idx_r > key_idx_r));
  assign mrg_hit = valid_r[idx_r] && after_key &&
                   (!cand_found_r || (rd_start_r < cand_start_r));

  // Adjacency test and saturating merged length.
  assign do_merge = have_prev_r &&
                    ((LEN_W + 1)'(prev_start_r) + (LEN_W + 1)'(prev_len_r) ==
                     (LEN_W + 1)'(cand_start_r));
  assign len_sum  = (LEN_W + 1)'(prev_len_r) + (LEN_W + 1)'(cand_len_r);
  assign len_sat  = len_sum[LEN_W] ? {LEN_W{1'b1}} : len_sum[LEN_W-1:0];

  assign pool_cl = (pool_r > POOL_MAX) ? POOL_MAX : pool_r;

  // First empty entry for a free request.
  always_comb begin
    free_avail = 1'b0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_avail = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Table write port and valid bit updates.
  always_comb begin
    we        = 1'b0;
    waddr     = '0;
    wstart    = '0;
    wlen      = '0;
    valid_nxt = valid_r;
    if (cmd.simple) begin
      case (kind_r)
        KIND_INIT: begin
          valid_nxt = '0;
          if (pool_cl != '0) begin
            we           = 1'b1;
            wlen         = LEN_W'(pool_cl);
            valid_nxt[0] = 1'b1;
          end
        end
        KIND_FREE: begin
          if ((units_r != '0) && free_avail) begin
            we                  = 1'b1;
            waddr               = free_idx;
            wstart              = offs_r;
            wlen                = units_r;
            valid_nxt[free_idx] = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.fit_apply) begin
      if (best_len_r > units_r) begin
        we     = 1'b1;
        waddr  = best_idx_r;
        wstart = best_start_r + units_r[UNIT_W-1:0];
        wlen   = best_len_r - units_r;
      end else begin
        valid_nxt[best_idx_r] = 1'b0;
      end
    end
    if (cmd.mrg_link && do_merge) begin
      we                    = 1'b1;
      waddr                 = cand_idx_r;
      wstart                = prev_start_r;
      wlen                  = len_sat;
      valid_nxt[prev_idx_r] = 1'b0;
    end
  end

  // Table storage. The read port fetches the entry the scan moves to next,
  // and a write to that entry on the same edge is passed straight through.
  always_ff @(posedge clk) begin
    if (we) begin
      start_mem[waddr] <= wstart;
      len_mem[waddr]   <= wlen;
    end
    if (we && (waddr == idx_nxt)) begin
      rd_start_r <= wstart;
      rd_len_r   <= wlen;
    end else begin
      rd_start_r <= start_mem[idx_nxt];
      rd_len_r   <= len_mem[idx_nxt];
    end
  end

  // Control registers: valid bits, pool size, flags and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      pool_r       <= POOL_MAX;
      best_found_r <= 1'b0;
      cand_found_r <= 1'b0;
      have_prev_r  <= 1'b0;
      merged_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      out_valid_r <= cmd.simple || cmd.fit_apply || cmd.fail;
      if (cfg_we) begin
        pool_r <= cfg_wdata;
      end
      if (cmd.fit_clr) begin
        best_found_r <= 1'b0;
      end else if (cmd.fit_step && fit_hit) begin
        best_found_r <= 1'b1;
      end
      if (cmd.mrg_clr) begin
        merged_r     <= 1'b0;
        have_prev_r  <= 1'b0;
        cand_found_r <= 1'b0;
      end else if (cmd.mrg_step && mrg_hit) begin
        cand_found_r <= 1'b1;
      end else if (cmd.mrg_link) begin
        cand_found_r <= 1'b0;
        have_prev_r  <= 1'b1;
        if (do_merge) begin
          merged_r <= 1'b1;
        end
      end
    end
  end

  // Request, scan and result payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      offs_r  <= in_block_offset;
      units_r <= in_block_units;
    end
    idx_r <= idx_nxt;
    if (cmd.fit_step && fit_hit) begin
      best_idx_r   <= idx_r;
      best_start_r <= rd_start_r;
      best_len_r   <= rd_len_r;
    end
    if (cmd.mrg_step && mrg_hit) begin
      cand_idx_r   <= idx_r;
      cand_start_r <= rd_start_r;
      cand_len_r   <= rd_len_r;
    end
    if (cmd.mrg_link) begin
      prev_idx_r  <= cand_idx_r;
      key_start_r <= cand_start_r;
      key_idx_r   <= cand_idx_r;
      if (do_merge) begin
        prev_len_r <= len_sat;
      end else begin
        prev_start_r <= cand_start_r;
        prev_len_r   <= cand_len_r;
      end
    end
    if (cmd.simple) begin
      out_granted_r <= '0;
      if ((kind_r == KIND_FREE) && (units_r != '0) && !free_avail) begin
        out_status_r <= ST_FULL;
      end else if (kind_r == KIND_ALLOC) begin
        out_status_r <= ST_NOFIT;
      end else begin
        out_status_r <= ST_OK;
      end
    end else if (cmd.fit_apply) begin
      out_granted_r <= best_start_r;
      out_status_r  <= ST_OK;
    end else if (cmd.fail) begin
      out_granted_r <= '0;
      out_status_r  <= ST_NOFIT;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_granted_offset = out_granted_r;
  assign out_status         = out_status_r;

endmodule

`default_nettype wire

FILE: tb/alloc_checker.sv
`default_nettype none

module alloc_checker import bfa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [POOL_W-1:0] cfg_wdata,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [UNIT_W-1:0] in_block_offset,
  input  wire logic [LEN_W-1:0]  in_block_units,
  input  wire logic              out_valid,
  input  wire logic [UNIT_W-1:0] out_granted_offset,
  input  wire logic [STAT_W-1:0] out_status,
  output int                     errors,
  output int                     outstanding,
  output int                     requests_seen,
  output int                     nofit_seen,
  output int                     full_seen,
  output int                     merge_passes
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};

  // Shadow copy of the free table and the pool register.
  logic [UNIT_W-1:0] blk_start [ENTRIES];
  logic [LEN_W-1:0]  blk_len   [ENTRIES];
  bit                blk_live  [ENTRIES];
  logic [POOL_W-1:0] pool_size;

  // Expected results, oldest first.
  logic [UNIT_W-1:0] want_offset [$];
  logic [STAT_W-1:0] want_status [$];

  task automatic report(input string what, input longint want, input longint got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    errors++;
  endtask

  // Smallest block that holds the request; ties go to the lower start.
  function automatic int best_block(input logic [LEN_W-1:0] need);
    int pick;
    pick = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (blk_live[i] && blk_len[i] >= need) begin
        if (pick < 0 || blk_len[i] < blk_len[pick] ||
            (blk_len[i] == blk_len[pick] && blk_start[i] < blk_start[pick]))
          pick = i;
      end
    end
    return pick;
  endfunction

  // One pass that joins touching blocks in offset order.
  function automatic bit coalesce();
    int ord [ENTRIES];
    int n, j, a, b;
    bit joined;
    longint sum;
    n = 0;
    joined = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (blk_live[i]) begin
        j = n;
        while (j > 0 && blk_start[ord[j-1]] > blk_start[i]) begin
          ord[j] = ord[j-1];
          j--;
        end
        ord[j] = i;
        n++;
      end
    end
    for (int i = 0; i + 1 < n; i++) begin
      a = ord[i];
      b = ord[i+1];
      if (longint'(blk_start[a]) + longint'(blk_len[a]) == longint'(blk_start[b])) begin
        sum = longint'(blk_len[a]) + longint'(blk_len[b]);
        blk_start[b] = blk_start[a];
        blk_len[b] = (sum > longint'(LEN_SAT)) ? LEN_SAT : LEN_W'(sum);
        blk_live[a] = 0;
        joined = 1;
      end
    end
    return joined;
  endfunction

  // Applies one request to the shadow table and queues its result.
  task automatic apply_request(input logic [KIND_W-1:0] kind,
                               input logic [UNIT_W-1:0] offs,
                               input logic [LEN_W-1:0] units);
    logic [UNIT_W-1:0] grant;
    logic [STAT_W-1:0] st;
    longint pool;
    int slot, hit;
    grant = '0;
    st = ST_OK;
    if (kind == KIND_INIT) begin
      pool = pool_size;
      if (pool > (longint'(1) << UNIT_W)) pool = longint'(1) << UNIT_W;
      foreach (blk_live[i]) blk_live[i] = 0;
      if (pool != 0) begin
        blk_start[0] = '0;
        blk_len[0] = LEN_W'(pool);
        blk_live[0] = 1;
      end
    end else if (kind == KIND_FREE) begin
      if (units != 0) begin
        slot = -1;
        for (int i = ENTRIES - 1; i >= 0; i--)
          if (!blk_live[i]) slot = i;
        if (slot < 0) begin
          st = ST_FULL;
        end else begin
          blk_start[slot] = offs;
          blk_len[slot] = units;
          blk_live[slot] = 1;
        end
      end
    end else if (kind == KIND_ALLOC) begin
      if (units == 0) begin
        st = ST_NOFIT;
      end else begin
        hit = best_block(units);
        while (hit < 0) begin
          merge_passes++;
          if (!coalesce()) break;
          hit = best_block(units);
        end
        if (hit < 0) begin
          st = ST_NOFIT;
        end else begin
          grant = blk_start[hit];
          if (blk_len[hit] > units) begin
            blk_start[hit] = blk_start[hit] + units[UNIT_W-1:0];
            blk_len[hit] = blk_len[hit] - units;
          end else begin
            blk_live[hit] = 0;
          end
        end
      end
    end
    if (st == ST_NOFIT) nofit_seen++;
    if (st == ST_FULL) full_seen++;
    want_offset = {want_offset, grant};
    want_status = {want_status, st};
  endtask

  // Watch both channels and the register port at every edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (blk_live[i]) blk_live[i] = 0;
      pool_size = POOL_W'(25'd16777216);
      want_offset.delete();
      want_status.delete();
      errors = 0;
      requests_seen = 0;
      nofit_seen = 0;
      full_seen = 0;
      merge_passes = 0;
    end else begin
      if (cfg_we) pool_size = cfg_wdata;
      if (out_valid) begin
        if (want_offset.size() == 0) begin
          report("unexpected result", 0, 1);
        end else begin
          if (out_granted_offset !== want_offset[0])
            report("granted offset", want_offset[0], out_granted_offset);
          if (out_status !== want_status[0])
            report("status", want_status[0], out_status);
          want_offset.delete(0);
          want_status.delete(0);
        end
      end
      if (start && !busy) begin
        requests_seen++;
        apply_request(in_kind, in_block_offset, in_block_units);
      end
    end
    outstanding <= want_offset.size();
  end
endmodule

`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none

module testbench import bfa_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
  localparam int RANDOM_ITEMS = 1130;
  localparam longint CYCLE_LIMIT = 20000000;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [POOL_W-1:0] cfg_wdata;
  logic              start;
  logic              busy;
  logic [KIND_W-1:0] in_kind;
  logic [UNIT_W-1:0] in_block_offset;
  logic [LEN_W-1:0]  in_block_units;
  logic              out_valid;
  logic [UNIT_W-1:0] out_granted_offset;
  logic [STAT_W-1:0] out_status;

  int errors, outstanding, requests_seen, nofit_seen, full_seen, merge_passes;
  longint cycles = 0;

  best_fit_allocator_coalescing_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .in_kind(in_kind),
    .in_block_offset(in_block_offset), .in_block_units(in_block_units),
    .out_valid(out_valid), .out_granted_offset(out_granted_offset),
    .out_status(out_status)
  );

  alloc_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .in_kind(in_kind),
    .in_block_offset(in_block_offset), .in_block_units(in_block_units),
    .out_valid(out_valid), .out_granted_offset(out_granted_offset),
    .out_status(out_status), .errors(errors), .outstanding(outstanding),
    .requests_seen(requests_seen), .nofit_seen(nofit_seen),
    .full_seen(full_seen), .merge_passes(merge_passes)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Requests in flight, and blocks the unit has handed out.
  logic [KIND_W-1:0] sent_kind [$];
  logic [LEN_W-1:0]  sent_units [$];
  logic [UNIT_W-1:0] held_offset [$];
  logic [LEN_W-1:0]  held_units [$];
  int burst_left;

  // Record granted blocks so later frees return real allocations.
  always @(posedge clk) begin
    if (rst_n && out_valid && sent_kind.size() != 0) begin
      if (sent_kind[0] == KIND_ALLOC && out_status == ST_OK) begin
        held_offset = {held_offset, out_granted_offset};
        held_units = {held_units, sent_units[0]};
      end
      sent_kind.delete(0);
      sent_units.delete(0);
    end
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // Present one request and hold it until the unit takes it.
  task automatic send(input logic [KIND_W-1:0] kind, input logic [UNIT_W-1:0] offs,
                      input logic [LEN_W-1:0] units);
    start <= 1'b1;
    in_kind <= kind;
    in_block_offset <= offs;
    in_block_units <= units;
    do @(posedge clk); while (busy);
    sent_kind = {sent_kind, kind};
    sent_units = {sent_units, units};
  endtask

  // Drop start for a random gap at the end of a burst.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_pool(input logic [POOL_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [LEN_W-1:0] pick_size(input longint pool);
    longint top;
    top = (pool < 8) ? 16 : ((pool > 64 * 8) ? 64 : pool / 8);
    if ($urandom_range(0, 9) == 0)
      return LEN_W'($urandom_range(1, (pool > 16777216) ? 16777216 : ((pool < 1) ? 16 : pool)));
    return LEN_W'($urandom_range(1, top));
  endfunction

  // One random step of one or more requests; returns how many were sent.
  task automatic random_step(input longint pool, output int count);
    int idx, mode;
    logic [UNIT_W-1:0] offs;
    logic [LEN_W-1:0] units, half;
    count = 1;
    mode = $urandom_range(0, 99);
    if (mode < 45 || (mode < 82 && held_offset.size() == 0)) begin
      send(KIND_ALLOC, UNIT_W'($urandom), pick_size(pool));
    end else if (mode < 82) begin
      // Return a held block, sometimes in two pieces so they can merge later.
      idx = $urandom_range(0, held_offset.size() - 1);
      offs = held_offset[idx];
      units = held_units[idx];
      held_offset.delete(idx);
      held_units.delete(idx);
      if (units > 1 && $urandom_range(0, 1)) begin
        half = units / 2;
        send(KIND_FREE, offs, half);
        pace();
        send(KIND_FREE, offs + half[UNIT_W-1:0], units - half);
        count = 2;
      end else begin
        send(KIND_FREE, offs, units);
      end
    end else if (mode < 86) begin
      // Flood the table with 34 stray frees, more than it has entries, so it reports full.
      count = 0;
      for (int k = 0; k < 34; k++) begin
        send(KIND_FREE, UNIT_W'($urandom), LEN_W'($urandom_range(1, 8)));
        count++;
        if (k != 33) pace();
      end
    end else if (mode < 88) begin
      drain();
      held_offset.delete();
      held_units.delete();
      send(KIND_INIT, UNIT_W'($urandom), LEN_W'($urandom));
    end else begin
      // Noise across the whole field ranges.
      units = ($urandom_range(0, 1)) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, 40));
      send(KIND_W'($urandom_range(0, 3)), UNIT_W'($urandom), units);
    end
    pace();
  endtask

  longint pools [8] = '{0, 1, 33554431, 256, 1024, 64, 4096, 16777216};

  // Stimulus and verdict.
  initial begin
    int sent, step_count, per_phase;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    start = 1'b0;
    in_kind = KIND_ALLOC;
    in_block_offset = '0;
    in_block_units = '0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: whole pool, wrap of the remainder, saturated merge, ties.
    send(KIND_INIT, '0, '0);
    send(KIND_ALLOC, '0, 25'd16777216);
    send(KIND_ALLOC, '0, 25'd1);
    send(KIND_ALLOC, '0, 25'd0);
    send(KIND_FREE, '0, 25'd0);
    send(KIND_UNKNOWN, 24'hFFFFFF, 25'h1FFFFFF);
    send(KIND_FREE, 24'hFFFFFF, 25'd5);
    send(KIND_ALLOC, '0, 25'd2);
    send(KIND_ALLOC, '0, 25'd3);
    send(KIND_FREE, 24'd0, 25'd10);
    send(KIND_FREE, 24'd10, 25'd33554426);
    send(KIND_ALLOC, '0, 25'h1FFFFFF);
    send(KIND_FREE, 24'd5, 25'd3);
    send(KIND_FREE, 24'd5, 25'd3);
    send(KIND_FREE, 24'd8, 25'd4);
    send(KIND_ALLOC, '0, 25'd9);
    send(KIND_ALLOC, '0, 25'd3);
    send(KIND_FREE, 24'd100, 25'd1);
    send(KIND_FREE, 24'd50, 25'd1);
    send(KIND_ALLOC, '0, 25'd1);
    send(KIND_INIT, '0, '0);
    send(KIND_ALLOC, '0, 25'd16777215);
    send(KIND_ALLOC, '0, 25'd1);

    // Random phases, each under its own pool size.
    sent = 0;
    per_phase = RANDOM_ITEMS / 8;
    foreach (pools[p]) begin
      write_pool(POOL_W'(pools[p]));
      held_offset.delete();
      held_units.delete();
      send(KIND_INIT, '0, '0);
      pace();
      for (int n = 0; n < per_phase; n += step_count) begin
        random_step(pools[p], step_count);
        sent += step_count;
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("ran %0d requests over 8 pool sizes: %0d without fit, %0d table full,",
             requests_seen, nofit_seen, full_seen);
    $display("%0d coalescing passes, %0d mismatches", merge_passes, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

`default_nettype wire
